@@ rtl/core/secc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secc_pkg
// Shared types, constants and calendar helpers of the epoch calendar clock.
// ----------------------------------------------------------------------------
package secc_pkg;

    localparam logic [11:0] EpochYear   = 12'd2000;
    localparam logic [16:0] SecsPerDay  = 17'd86400;
    localparam logic [11:0] SecsPerHour = 12'd3600;
    localparam logic [5:0]  SecsPerMin  = 6'd60;

    localparam logic [31:0] SecsLeapYear   = 32'd31622400;
    localparam logic [31:0] SecsCommonYear = 32'd31536000;

    // number of reciprocal quotient steps in each division
    localparam int DivDaySteps  = 1;
    localparam int DivHourSteps = 1;
    localparam int DivMinSteps  = 1;

    // reciprocals once the divisor's power-of-two factor is shifted out:
    // x/675 for x below 2^25, x/225 for x below 2^13, x/15 for x below 2^10
    localparam logic [25:0] RecipDay  = 26'd50903317;
    localparam logic [13:0] RecipHour = 14'd9321;
    localparam logic [10:0] RecipMin  = 11'd1093;

    // item kinds
    localparam logic [1:0] KindTick = 2'd0;
    localparam logic [1:0] KindSet  = 2'd1;
    localparam logic [1:0] KindGet  = 2'd2;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_TICK,
        DP_SET_START,
        DP_SET_YEAR,
        DP_SET_MONTH,
        DP_TERM,
        DP_GET_START,
        DP_DIV_STEP,
        DP_LOAD_HOUR,
        DP_LOAD_MIN,
        DP_LOAD_CAL,
        DP_GET_YEAR,
        DP_GET_MONTH,
        DP_LOAD_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        DIV_BY_DAY,
        DIV_BY_HOUR,
        DIV_BY_MIN
    } t_div_sel;

    typedef enum logic [1:0] {
        TERM_DAY,
        TERM_HOUR,
        TERM_MIN,
        TERM_SEC
    } t_term_sel;

    typedef struct packed {
        t_dp_op    op;
        t_div_sel  div_sel;
        t_term_sel term_sel;
        logic      term_add;
    } t_dp_cmd;

    typedef struct packed {
        logic set_year_more;
        logic set_month_more;
        logic get_year_more;
        logic get_month_more;
    } t_dp_status;

    // gregorian leap test; y/100 found by reciprocal multiply on y/4
    function automatic logic is_leap(input logic [11:0] y);
        logic [9:0]  v;
        logic [20:0] p;
        logic [5:0]  q;
        logic [9:0]  r;
        v = y[11:2];
        p = 21'(v) * 21'd1311;
        q = p[20:15];
        r = v - (10'(q) * 10'd25);
        return (y[1:0] == 2'b00) && ((r != 10'd0) || (q[1:0] == 2'b00));
    endfunction

    function automatic logic [8:0] year_days(input logic [11:0] y);
        return is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [31:0] year_secs(input logic [11:0] y);
        return is_leap(y) ? SecsLeapYear : SecsCommonYear;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] month_secs(input logic [3:0] m, input logic leap);
        return 32'(22'(month_days(m, leap)) * 22'(SecsPerDay));
    endfunction

endpackage

@@ rtl/core/secc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secc_datapath
// Seconds count, calendar accumulator, reciprocal divider and walks.
// ----------------------------------------------------------------------------
module secc_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  secc_pkg::t_dp_cmd     i_cmd,
    input  logic [11:0]           i_set_year,
    input  logic [3:0]            i_set_month,
    input  logic [4:0]            i_set_day,
    input  logic [4:0]            i_set_hour,
    input  logic [5:0]            i_set_minute,
    input  logic [5:0]            i_set_second,
    output secc_pkg::t_dp_status  o_status,
    output logic [11:0]           o_year,
    output logic [3:0]            o_month,
    output logic [4:0]            o_day,
    output logic [4:0]            o_hour,
    output logic [5:0]            o_minute,
    output logic [5:0]            o_second
);

    logic [31:0] r_epoch;

    logic [11:0] r_set_year;
    logic [3:0]  r_set_month;
    logic [4:0]  r_set_day;
    logic [4:0]  r_set_hour;
    logic [5:0]  r_set_minute;
    logic [5:0]  r_set_second;

    logic [11:0] r_year;
    logic [3:0]  r_mon;
    logic [31:0] r_term;
    logic [31:0] r_dvd;
    logic [15:0] r_quo;
    logic [15:0] r_days;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;
    logic [5:0]  r_sec;

    logic [11:0] r_out_year;
    logic [3:0]  r_out_month;
    logic [4:0]  r_out_day;
    logic [4:0]  r_out_hour;
    logic [5:0]  r_out_minute;
    logic [5:0]  r_out_second;

    logic [50:0] day_prod;
    logic [26:0] hour_prod;
    logic [20:0] min_prod;
    logic [15:0] n_quo;
    logic [31:0] n_term;

    // quotient by reciprocal multiply, power-of-two factor of the divisor shifted out first
    always_comb begin
        day_prod  = 51'(r_dvd[31:7]) * 51'(secc_pkg::RecipDay);
        hour_prod = 27'(r_dvd[16:4]) * 27'(secc_pkg::RecipHour);
        min_prod  = 21'(r_dvd[11:2]) * 21'(secc_pkg::RecipMin);
        unique case (i_cmd.div_sel)
            secc_pkg::DIV_BY_HOUR: n_quo = 16'(hour_prod[26:21]);
            secc_pkg::DIV_BY_MIN:  n_quo = 16'(min_prod[20:14]);
            default:               n_quo = day_prod[50:35];
        endcase
    end

    // product terms of a set, one per step
    always_comb begin
        unique case (i_cmd.term_sel)
            secc_pkg::TERM_DAY: begin
                if (r_set_day == 5'd0) begin
                    n_term = 32'd0 - 32'(secc_pkg::SecsPerDay);
                end else begin
                    n_term = 32'(22'(r_set_day - 5'd1) * 22'(secc_pkg::SecsPerDay));
                end
            end
            secc_pkg::TERM_HOUR:
                n_term = 32'(17'(r_set_hour) * 17'(secc_pkg::SecsPerHour));
            secc_pkg::TERM_MIN:
                n_term = 32'(12'(r_set_minute) * 12'(secc_pkg::SecsPerMin));
            secc_pkg::TERM_SEC:
                n_term = 32'(r_set_second);
        endcase
    end

    always_comb begin
        o_status.set_year_more  = (r_year < r_set_year);
        o_status.set_month_more = (r_mon < r_set_month) && (r_mon <= 4'd12);
        o_status.get_year_more  = (r_days >= 16'(secc_pkg::year_days(r_year)));
        o_status.get_month_more = (r_mon < 4'd12) &&
            (r_days >= 16'(secc_pkg::month_days(r_mon, secc_pkg::is_leap(r_year))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= 32'd0;
        end else begin
            case (i_cmd.op)
                secc_pkg::DP_TICK:      r_epoch <= r_epoch + 32'd1;
                secc_pkg::DP_SET_START: r_epoch <= 32'd0;
                secc_pkg::DP_SET_YEAR:  r_epoch <= r_epoch + secc_pkg::year_secs(r_year);
                secc_pkg::DP_SET_MONTH:
                    r_epoch <= r_epoch +
                        secc_pkg::month_secs(r_mon, secc_pkg::is_leap(r_set_year));
                secc_pkg::DP_TERM: begin
                    if (i_cmd.term_add) begin
                        r_epoch <= r_epoch + r_term;
                    end
                end
                default: r_epoch <= r_epoch;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            secc_pkg::DP_SET_START: begin
                r_set_year   <= i_set_year;
                r_set_month  <= i_set_month;
                r_set_day    <= i_set_day;
                r_set_hour   <= i_set_hour;
                r_set_minute <= i_set_minute;
                r_set_second <= i_set_second;
                r_year       <= secc_pkg::EpochYear;
                r_mon        <= 4'd1;
            end
            secc_pkg::DP_SET_YEAR:  r_year <= r_year + 12'd1;
            secc_pkg::DP_SET_MONTH: r_mon  <= r_mon + 4'd1;
            secc_pkg::DP_TERM:      r_term <= n_term;
            secc_pkg::DP_GET_START: begin
                r_dvd <= r_epoch;
            end
            secc_pkg::DP_DIV_STEP: begin
                r_quo <= n_quo;
            end
            secc_pkg::DP_LOAD_HOUR: begin
                r_days <= r_quo;
                r_dvd  <= r_dvd - 32'(r_quo) * 32'(secc_pkg::SecsPerDay);
            end
            secc_pkg::DP_LOAD_MIN: begin
                r_hour <= r_quo[4:0];
                r_dvd  <= r_dvd - 32'(r_quo) * 32'(secc_pkg::SecsPerHour);
            end
            secc_pkg::DP_LOAD_CAL: begin
                r_min  <= r_quo[5:0];
                r_sec  <= 6'(r_dvd - 32'(r_quo) * 32'(secc_pkg::SecsPerMin));
                r_year <= secc_pkg::EpochYear;
                r_mon  <= 4'd1;
            end
            secc_pkg::DP_GET_YEAR: begin
                r_days <= r_days - 16'(secc_pkg::year_days(r_year));
                r_year <= r_year + 12'd1;
            end
            secc_pkg::DP_GET_MONTH: begin
                r_days <= r_days -
                    16'(secc_pkg::month_days(r_mon, secc_pkg::is_leap(r_year)));
                r_mon  <= r_mon + 4'd1;
            end
            secc_pkg::DP_LOAD_OUT: begin
                r_out_year   <= r_year;
                r_out_month  <= r_mon;
                r_out_day    <= r_days[4:0] + 5'd1;
                r_out_hour   <= r_hour;
                r_out_minute <= r_min;
                r_out_second <= r_sec;
            end
            default: begin
            end
        endcase
    end

    assign o_year   = r_out_year;
    assign o_month  = r_out_month;
    assign o_day    = r_out_day;
    assign o_hour   = r_out_hour;
    assign o_minute = r_out_minute;
    assign o_second = r_out_second;

endmodule

@@ rtl/core/secc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secc_ctrl
// Sequencer for tick, set and get items and owner of the output valid flag.
// ----------------------------------------------------------------------------
module secc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [1:0]            i_kind,
    input  logic                  i_out_stall,
    input  secc_pkg::t_dp_status  i_status,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output secc_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SET_YEAR,
        S_SET_MONTH,
        S_SET_TERM,
        S_DIV_DAY,
        S_LD_HOUR,
        S_DIV_HOUR,
        S_LD_MIN,
        S_DIV_MIN,
        S_LD_CAL,
        S_GET_YEAR,
        S_GET_MONTH,
        S_DONE
    } t_state;

    localparam logic [4:0] TermLast    = 5'd4;
    localparam logic [4:0] DayLast     = 5'(secc_pkg::DivDaySteps - 1);
    localparam logic [4:0] HourLast    = 5'(secc_pkg::DivHourSteps - 1);
    localparam logic [4:0] MinLast     = 5'(secc_pkg::DivMinSteps - 1);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        o_cmd.op       = secc_pkg::DP_IDLE;
        o_cmd.div_sel  = secc_pkg::DIV_BY_DAY;
        o_cmd.term_sel = secc_pkg::t_term_sel'(r_cnt[1:0]);
        o_cmd.term_add = 1'b0;
        n_state        = r_state;
        n_cnt          = r_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_kind == secc_pkg::KindTick) begin
                        o_cmd.op = secc_pkg::DP_TICK;
                    end else if (i_kind == secc_pkg::KindSet) begin
                        o_cmd.op = secc_pkg::DP_SET_START;
                        n_state  = S_SET_YEAR;
                    end else if (i_kind == secc_pkg::KindGet) begin
                        o_cmd.op = secc_pkg::DP_GET_START;
                        n_cnt    = 5'd0;
                        n_state  = S_DIV_DAY;
                    end else begin
                    end
                end
            end
            S_SET_YEAR: begin
                if (i_status.set_year_more) begin
                    o_cmd.op = secc_pkg::DP_SET_YEAR;
                end else begin
                    n_state = S_SET_MONTH;
                end
            end
            S_SET_MONTH: begin
                if (i_status.set_month_more) begin
                    o_cmd.op = secc_pkg::DP_SET_MONTH;
                end else begin
                    n_cnt   = 5'd0;
                    n_state = S_SET_TERM;
                end
            end
            S_SET_TERM: begin
                // add the previous term while the next one is formed
                o_cmd.op       = secc_pkg::DP_TERM;
                o_cmd.term_add = (r_cnt != 5'd0);
                if (r_cnt == TermLast) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_DIV_DAY: begin
                o_cmd.op      = secc_pkg::DP_DIV_STEP;
                o_cmd.div_sel = secc_pkg::DIV_BY_DAY;
                if (r_cnt == DayLast) begin
                    n_state = S_LD_HOUR;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_LD_HOUR: begin
                o_cmd.op = secc_pkg::DP_LOAD_HOUR;
                n_cnt    = 5'd0;
                n_state  = S_DIV_HOUR;
            end
            S_DIV_HOUR: begin
                o_cmd.op      = secc_pkg::DP_DIV_STEP;
                o_cmd.div_sel = secc_pkg::DIV_BY_HOUR;
                if (r_cnt == HourLast) begin
                    n_state = S_LD_MIN;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_LD_MIN: begin
                o_cmd.op = secc_pkg::DP_LOAD_MIN;
                n_cnt    = 5'd0;
                n_state  = S_DIV_MIN;
            end
            S_DIV_MIN: begin
                o_cmd.op      = secc_pkg::DP_DIV_STEP;
                o_cmd.div_sel = secc_pkg::DIV_BY_MIN;
                if (r_cnt == MinLast) begin
                    n_state = S_LD_CAL;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_LD_CAL: begin
                o_cmd.op = secc_pkg::DP_LOAD_CAL;
                n_state  = S_GET_YEAR;
            end
            S_GET_YEAR: begin
                if (i_status.get_year_more) begin
                    o_cmd.op = secc_pkg::DP_GET_YEAR;
                end else begin
                    n_state = S_GET_MONTH;
                end
            end
            S_GET_MONTH: begin
                if (i_status.get_month_more) begin
                    o_cmd.op = secc_pkg::DP_GET_MONTH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op = secc_pkg::DP_LOAD_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.op == secc_pkg::DP_LOAD_OUT) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/seconds_epoch_calendar_clock.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_epoch_calendar_clock
// Seconds-since-2000 counter with calendar set and calendar read-back.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall with kind and set fields; a transfer
//   happens at a clock edge with valid high and stall low
//   tick: adds one second in the transfer cycle, next item the cycle after
//   set: walks whole years (one per cycle), then whole months (one per cycle),
//     then adds the day/hour/minute/second terms
//   get: reciprocal multiplies split the count into days, hours, minutes and
//     seconds, then the year walk and the month walk run at one year or month
//     per cycle; the next item is taken once the result is loaded into the
//     output register
//   kind 3 is taken and dropped with no effect on the count
//   output channel: o_out_valid / i_out_stall, result held in an output
//   register, so a new item is taken while a result waits; a second get
//   parks at its end until the register frees up
//   reset: synchronous, clears the seconds count to zero and o_out_valid, the only one of the two valids
// ----------------------------------------------------------------------------
module seconds_epoch_calendar_clock (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_set_year,
    input  logic [3:0]  i_set_month,
    input  logic [4:0]  i_set_day,
    input  logic [4:0]  i_set_hour,
    input  logic [5:0]  i_set_minute,
    input  logic [5:0]  i_set_second,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    // command and status between sequencer and datapath
    secc_pkg::t_dp_cmd    dp_cmd;
    secc_pkg::t_dp_status dp_status;

    // sequencer: accepts items only when idle, owns the output valid
    secc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    // datapath: seconds count, divider, calendar walks and result register
    secc_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_set_year   (i_set_year),
        .i_set_month  (i_set_month),
        .i_set_day    (i_set_day),
        .i_set_hour   (i_set_hour),
        .i_set_minute (i_set_minute),
        .i_set_second (i_set_second),
        .o_status     (dp_status),
        .o_year       (o_year),
        .o_month      (o_month),
        .o_day        (o_day),
        .o_hour       (o_hour),
        .o_minute     (o_minute),
        .o_second     (o_second)
    );

endmodule

@@ rtl/core/secc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secc_checker
// Port-level checks of the epoch calendar clock, bound to the top level.
// ----------------------------------------------------------------------------
module secc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_kind,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [11:0] o_year,
    input logic [3:0]  o_month,
    input logic [4:0]  o_day,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic [5:0]  o_second
);

    // a result waiting under stall stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // and keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_year) && $stable(o_month) && $stable(o_day) &&
            $stable(o_hour) && $stable(o_minute) && $stable(o_second))
        else $error("stalled result changed");

    // only a set or get transfer starts a multi-cycle job
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |->
            $past(i_in_valid) &&
            ($past(i_kind) == secc_pkg::KindSet || $past(i_kind) == secc_pkg::KindGet))
        else $error("busy without a set or get transfer");

    // a result appears only at the end of a get job
    a_out_from_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a job in progress");

endmodule

bind seconds_epoch_calendar_clock secc_checker u_checker (.*);

@@ test/seconds_epoch_calendar_clock_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_epoch_calendar_clock_tb
// Self-checking bench for the epoch calendar clock. A queue of tick, set,
// read and spare-kind transfers feeds a clocked driver. A behavioural copy of
// the seconds count predicts every calendar read-back, and a clocked monitor
// compares each result field by field. Both sides insert random idle and
// stall cycles, with quiet spells of none.
// ----------------------------------------------------------------------------
module seconds_epoch_calendar_clock_tb;

    // kind 3 has no meaning; the block must swallow it
    localparam logic [1:0]  KindUnused  = 2'd3;
    localparam logic [31:0] DaySecs     = 32'd86400;
    localparam int          WaitMax     = 8;
    localparam int          RandomItems = 550;
    // idle spell after the last read, leaving room for any stray result
    localparam int          DrainCycles = 300;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_item;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_calendar;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_out_stall = 1'b0;
    t_item       on_wire     = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;

    // items still to be offered, and calendar reads still owed by the block
    t_item       pending_items[$];
    t_calendar   expected_dates[$];
    // our own copy of the seconds count, updated at each accepted tick or set
    logic [31:0] clock_seconds = '0;
    int unsigned send_wait     = 0;
    int unsigned stall_wait    = 0;
    bit          quiet_spell   = 1'b0;
    int          error_count   = 0;

    seconds_epoch_calendar_clock dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (on_wire.kind),
        .i_set_year   (on_wire.year),
        .i_set_month  (on_wire.month),
        .i_set_day    (on_wire.day),
        .i_set_hour   (on_wire.hour),
        .i_set_minute (on_wire.minute),
        .i_set_second (on_wire.second),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_year       (o_year),
        .o_month      (o_month),
        .o_day        (o_day),
        .o_hour       (o_hour),
        .o_minute     (o_minute),
        .o_second     (o_second)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // calendar arithmetic, all sums wrapping at 32 bits
    // ------------------------------------------------------------------------
    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input bit leap);
        case (m)
            2:          return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    function automatic logic [31:0] calendar_to_seconds(input t_item it);
        logic [31:0] sum;
        logic [31:0] day_index;
        int unsigned y;
        int unsigned m;
        bit          leap;
        sum  = '0;
        leap = leap_year(it.year);
        // years below the epoch add nothing; large years wrap the sum
        for (y = secc_pkg::EpochYear; y < it.year; y++)
            sum = sum + (leap_year(y) ? 32'd366 : 32'd365) * DaySecs;
        // month zero adds nothing, months past december stop at twelve
        for (m = 1; m < it.month && m <= 12; m++)
            sum = sum + 32'(month_length(m, leap)) * DaySecs;
        // day zero wraps to one day before the first
        day_index = 32'(it.day) - 32'd1;
        sum = sum + day_index * DaySecs;
        sum = sum + 32'(it.hour) * 32'd3600 + 32'(it.minute) * 32'd60 + 32'(it.second);
        return sum;
    endfunction

    function automatic t_calendar seconds_to_calendar(input logic [31:0] count);
        t_calendar   c;
        logic [31:0] rest;
        int unsigned yr;
        int unsigned mo;
        int unsigned ylen;
        bit          leap;
        c.second = 6'(count % 60);
        rest     = count / 60;
        c.minute = 6'(rest % 60);
        rest     = rest / 60;
        c.hour   = 5'(rest % 24);
        rest     = rest / 24;
        yr   = secc_pkg::EpochYear;
        ylen = leap_year(yr) ? 366 : 365;
        while (rest >= ylen) begin
            rest = rest - ylen;
            yr++;
            ylen = leap_year(yr) ? 366 : 365;
        end
        leap = (ylen == 366);
        mo   = 1;
        while (mo < 12 && rest >= month_length(mo, leap)) begin
            rest = rest - month_length(mo, leap);
            mo++;
        end
        c.year  = 12'(yr);
        c.month = 4'(mo);
        c.day   = 5'(rest + 1);
        return c;
    endfunction

    // advance the predicted count for one accepted transfer
    task automatic record_transfer(input t_item it);
        case (it.kind)
            secc_pkg::KindTick: clock_seconds = clock_seconds + 32'd1;
            secc_pkg::KindSet:  clock_seconds = calendar_to_seconds(it);
            secc_pkg::KindGet:  expected_dates.push_back(seconds_to_calendar(clock_seconds));
            default:  ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int unsigned draw_wait();
        return quiet_spell ? 0 : $urandom_range(0, WaitMax);
    endfunction

    // fields not used by the kind are random, so the block must ignore them
    function automatic t_item random_item(input logic [1:0] kind);
        t_item it;
        it.kind   = kind;
        it.year   = 12'($urandom);
        it.month  = 4'($urandom);
        it.day    = 5'($urandom);
        it.hour   = 5'($urandom);
        it.minute = 6'($urandom);
        it.second = 6'($urandom);
        return it;
    endfunction

    task automatic queue_set(input int unsigned y, input int unsigned mo, input int unsigned d,
                             input int unsigned h, input int unsigned mi, input int unsigned s);
        t_item it;
        it.kind   = secc_pkg::KindSet;
        it.year   = 12'(y);
        it.month  = 4'(mo);
        it.day    = 5'(d);
        it.hour   = 5'(h);
        it.minute = 6'(mi);
        it.second = 6'(s);
        pending_items.push_back(it);
    endtask

    task automatic queue_plain(input logic [1:0] kind);
        pending_items.push_back(random_item(kind));
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result();
        t_calendar want;
        if (expected_dates.size() == 0) begin
            $error("result with no read outstanding: %0d-%0d-%0d %0d:%0d:%0d",
                   o_year, o_month, o_day, o_hour, o_minute, o_second);
            error_count++;
        end else begin
            want = expected_dates.pop_front();
            check_field("year", want.year, o_year);
            check_field("month", want.month, o_month);
            check_field("day", want.day, o_day);
            check_field("hour", want.hour, o_hour);
            check_field("minute", want.minute, o_minute);
            check_field("second", want.second, o_second);
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers the queue one transfer at a time, with a random gap
    // before each; valid stays up untouched while the block stalls
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                record_transfer(on_wire);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    on_wire    <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    // now and then switch between gappy traffic and none at all
                    if ($urandom_range(0, 39) == 0) quiet_spell = !quiet_spell;
                    send_wait = draw_wait();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each result transfer, then holds off for a random spell
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_result();
                stall_wait = draw_wait();
            end
            if (stall_wait > 0) begin
                stall_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned issued;
        int unsigned pick;
        int unsigned y;
        int unsigned mo;
        int unsigned dim;

        // count straight out of reset, then one second on
        queue_plain(secc_pkg::KindGet);
        queue_plain(secc_pkg::KindTick);
        queue_plain(secc_pkg::KindGet);
        // last second before the count wraps, then the wrap back to the epoch
        queue_set(2136, 2, 7, 6, 28, 15);
        queue_plain(secc_pkg::KindGet);
        queue_plain(secc_pkg::KindTick);
        queue_plain(secc_pkg::KindGet);
        // leap day rolling into march
        queue_set(2004, 2, 29, 23, 59, 59);
        queue_plain(secc_pkg::KindTick);
        queue_plain(secc_pkg::KindGet);
        // century year that is not a leap year
        queue_set(2100, 2, 28, 23, 59, 59);
        queue_plain(secc_pkg::KindTick);
        queue_plain(secc_pkg::KindGet);
        // day 366 of a leap year, then new year
        queue_set(2000, 12, 31, 23, 59, 59);
        queue_plain(secc_pkg::KindGet);
        queue_plain(secc_pkg::KindTick);
        queue_plain(secc_pkg::KindGet);
        // year before the epoch, month zero, day zero
        queue_set(0, 0, 0, 0, 0, 0);
        queue_plain(secc_pkg::KindGet);
        // every field at its all-ones value: huge year, month past december
        queue_set(4095, 15, 31, 31, 63, 63);
        queue_plain(secc_pkg::KindGet);
        queue_set(1999, 13, 1, 0, 0, 0);
        queue_plain(secc_pkg::KindGet);
        // spare kind must leave the count alone
        queue_plain(KindUnused);
        queue_plain(secc_pkg::KindGet);

        // random episodes: a set, then a short run of ticks, reads and spare kinds
        issued = 0;
        while (issued < RandomItems) begin
            if ($urandom_range(0, 24) == 0) begin
                queue_plain(secc_pkg::KindSet);
            end else begin
                y   = $urandom_range(2000, 2136);
                mo  = $urandom_range(1, 12);
                dim = month_length(mo, leap_year(y));
                // park just short of a day, month or year boundary
                if ($urandom_range(0, 2) == 0)
                    queue_set(y, mo, dim, 23, 59, $urandom_range(57, 59));
                else
                    queue_set(y, mo, $urandom_range(1, dim), $urandom_range(0, 23),
                              $urandom_range(0, 59), $urandom_range(0, 59));
            end
            issued++;
            repeat ($urandom_range(1, 10)) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    queue_plain(KindUnused);
                end else begin
                    queue_plain(pick < 55 ? secc_pkg::KindTick : secc_pkg::KindGet);
                    issued++;
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid || expected_dates.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // safety net, several times the slowest legal run
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ seconds_epoch_calendar_clock.f @@
rtl/core/secc_pkg.sv
rtl/core/secc_datapath.sv
rtl/core/secc_ctrl.sv
rtl/core/seconds_epoch_calendar_clock.sv
rtl/core/secc_checker.sv
test/seconds_epoch_calendar_clock_tb.sv
